/* rtl/ddmc_pkg.sv */
// Shared types, command codes and constants for the maneuver controller.
`timescale 1ns / 1ps

package ddmc_pkg;

  // Command codes
  localparam logic [2:0] KIND_FWD  = 3'd0;
  localparam logic [2:0] KIND_BWD  = 3'd1;
  localparam logic [2:0] KIND_TURN = 3'd2;
  localparam logic [2:0] KIND_STOP = 3'd3;
  localparam logic [2:0] KIND_TICK = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_MOVE_PCT  = 2'd0;
  localparam logic [1:0] REG_TURN_PCT  = 2'd1;
  localparam logic [1:0] REG_TURN_DLY  = 2'd2;

  localparam int unsigned PCT_MAX = 100;
  localparam int unsigned PCT_RST = 100;
  localparam int unsigned DLY_RST = 7;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x <= 10000
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         speed_percent;
    logic               timed;
    logic [15:0]        duration_ms;
    logic signed [15:0] angle;
    logic               notify;
  } item_t;

  typedef struct packed {
    logic signed [7:0]  left_percent;
    logic signed [7:0]  right_percent;
    logic               motor_update;
    logic               maneuver_done;
    logic [1:0]         done_kind;
    logic signed [15:0] done_parameter;
    logic               moving;
    logic               maneuvering;
  } result_t;

  // Derived configuration handed to the step logic
  typedef struct packed {
    logic [19:0] move_recip;   // moving percent * RECIP_100
    logic [6:0]  turn_wheel;   // trunc(t * t / 100)
    logic [15:0] turn_delay;   // ms per unit of angle
  } cfg_t;

endpackage

/* rtl/ddmc_cfg.sv */
// Configuration registers with precomputed scale factors.
`timescale 1ns / 1ps

module ddmc_cfg import ddmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  logic [6:0]  pct;
  logic        pct_ok;
  logic        wr;
  logic [19:0] pct_recip;
  logic [26:0] wheel_prod;
  logic [19:0] move_recip_q, move_recip_d;
  logic [6:0]  turn_wheel_q, turn_wheel_d;
  logic [15:0] turn_delay_q, turn_delay_d;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign pct         = cfg_data_i[6:0];
  assign pct_ok      = (pct <= 7'(PCT_MAX));
  assign pct_recip   = 20'(pct) * 20'(RECIP_100);
  assign wheel_prod  = 27'(pct) * 27'(pct_recip);

  always_comb begin
    move_recip_d = move_recip_q;
    turn_wheel_d = turn_wheel_q;
    turn_delay_d = turn_delay_q;
    if (wr) begin
      unique case (cfg_index_i)
        REG_MOVE_PCT: if (pct_ok) move_recip_d = pct_recip;
        REG_TURN_PCT: if (pct_ok) turn_wheel_d = wheel_prod[RECIP_SHIFT +: 7];
        REG_TURN_DLY: turn_delay_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_recip_q <= 20'(PCT_RST * RECIP_100);
      turn_wheel_q <= 7'(PCT_RST * PCT_RST / PCT_MAX);
      turn_delay_q <= 16'(DLY_RST);
    end else begin
      move_recip_q <= move_recip_d;
      turn_wheel_q <= turn_wheel_d;
      turn_delay_q <= turn_delay_d;
    end
  end

  assign cfg_o.move_recip = move_recip_q;
  assign cfg_o.turn_wheel = turn_wheel_q;
  assign cfg_o.turn_delay = turn_delay_q;

endmodule

/* rtl/ddmc_step.sv */
// Drive state and single-pass command evaluation.
`timescale 1ns / 1ps

module ddmc_step import ddmc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [7:0]  cur_q, cur_d;           // signed straight speed, -100..100
  logic        active_q, active_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] len_q, len_d;
  logic [1:0]  mkind_q, mkind_d;
  logic [15:0] mval_q, mval_d;
  logic        mnotify_q, mnotify_d;

  logic        is_fwd;
  logic [6:0]  clamped;
  logic [7:0]  clamped8;
  logic [26:0] drive_prod;
  logic [7:0]  drive8;
  logic [8:0]  spd9, target9, cur9;
  logic [16:0] angle17, angle_mag;
  logic [32:0] turn_len;
  logic [7:0]  wheel8;
  logic [31:0] el_inc;

  assign is_fwd     = (item_i.kind == KIND_FWD);
  assign clamped    = (item_i.speed_percent > 8'(PCT_MAX)) ? 7'(PCT_MAX)
                                                          : item_i.speed_percent[6:0];
  assign clamped8   = {1'b0, clamped};
  assign drive_prod = 27'(clamped) * 27'(cfg_i.move_recip);
  assign drive8     = {1'b0, drive_prod[RECIP_SHIFT +: 7]};
  assign spd9       = {1'b0, item_i.speed_percent};
  assign target9    = is_fwd ? spd9 : (~spd9 + 9'd1);
  assign cur9       = {cur_q[7], cur_q};
  assign angle17    = {item_i.angle[15], item_i.angle};
  assign angle_mag  = angle17[16] ? (~angle17 + 17'd1) : angle17;
  assign turn_len   = 33'(angle_mag) * 33'(cfg_i.turn_delay);
  assign wheel8     = {1'b0, cfg_i.turn_wheel};
  assign el_inc     = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;

  always_comb begin
    cur_d     = cur_q;
    active_d  = active_q;
    elapsed_d = elapsed_q;
    len_d     = len_q;
    mkind_d   = mkind_q;
    mval_d    = mval_q;
    mnotify_d = mnotify_q;
    res_o     = '0;

    unique case (item_i.kind) inside
      KIND_FWD, KIND_BWD: begin
        if (item_i.timed) begin
          active_d  = 1'b1;
          elapsed_d = '0;
          len_d     = {16'd0, item_i.duration_ms};
          mkind_d   = item_i.kind[1:0];
          mval_d    = {8'd0, item_i.speed_percent};
          mnotify_d = item_i.notify;
        end
        // repeat check against the unclamped request
        if (cur9 != target9) begin
          cur_d                = is_fwd ? clamped8 : (~clamped8 + 8'd1);
          res_o.left_percent   = is_fwd ? drive8 : (~drive8 + 8'd1);
          res_o.right_percent  = res_o.left_percent;
          res_o.motor_update   = 1'b1;
        end
      end
      KIND_TURN: begin
        cur_d               = '0;
        res_o.left_percent  = item_i.angle[15] ? (~wheel8 + 8'd1) : wheel8;
        res_o.right_percent = item_i.angle[15] ? wheel8 : (~wheel8 + 8'd1);
        res_o.motor_update  = 1'b1;
        active_d            = 1'b1;
        elapsed_d           = '0;
        len_d               = turn_len[31:0];
        mkind_d             = KIND_TURN[1:0];
        mval_d              = item_i.angle;
        mnotify_d           = item_i.notify;
      end
      KIND_STOP: begin
        cur_d              = '0;
        active_d           = 1'b0;
        elapsed_d          = '0;
        len_d              = '0;
        mkind_d            = '0;
        mval_d             = '0;
        mnotify_d          = 1'b0;
        res_o.motor_update = 1'b1;
      end
      KIND_TICK: begin
        if (active_q) begin
          if (el_inc > len_q) begin
            cur_d              = '0;
            active_d           = 1'b0;
            elapsed_d          = '0;
            len_d              = '0;
            mkind_d            = '0;
            mval_d             = '0;
            mnotify_d          = 1'b0;
            res_o.motor_update = 1'b1;
            if (mnotify_q) begin
              res_o.maneuver_done  = 1'b1;
              res_o.done_kind      = mkind_q;
              res_o.done_parameter = mval_q;
            end
          end else begin
            elapsed_d = el_inc;
          end
        end
      end
      default: ;
    endcase

    res_o.moving      = (cur_d != '0);
    res_o.maneuvering = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      active_q  <= 1'b0;
      elapsed_q <= '0;
      len_q     <= '0;
      mkind_q   <= '0;
      mval_q    <= '0;
      mnotify_q <= 1'b0;
    end else if (fire_i) begin
      cur_q     <= cur_d;
      active_q  <= active_d;
      elapsed_q <= elapsed_d;
      len_q     <= len_d;
      mkind_q   <= mkind_d;
      mval_q    <= mval_d;
      mnotify_q <= mnotify_d;
    end
  end

endmodule

/* rtl/diff_drive_maneuver_controller.sv */
// Top level: differential drive maneuver controller with registered in/out stages.
// Registers from input transfer to earliest result transfer: input reg, then result reg.
// Throughput: one command per cycle unless stalled; exactly one result transfer per command.
// The step logic is one short pass: one multiply for straight drive or turn length.
// Reset (rst_ni low, async) clears both stages, speed and maneuver state, and
// loads register defaults: moving 100 %, turning 100 %, turn delay 7 ms per unit.
`timescale 1ns / 1ps

module diff_drive_maneuver_controller import ddmc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [7:0]         speed_percent_i,
  input  logic               timed_i,
  input  logic [15:0]        duration_ms_i,
  input  logic signed [15:0] angle_i,
  input  logic               notify_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [7:0]  left_percent_o,
  output logic signed [7:0]  right_percent_o,
  output logic               motor_update_o,
  output logic               maneuver_done_o,
  output logic [1:0]         done_kind_o,
  output logic signed [15:0] done_parameter_o,
  output logic               moving_o,
  output logic               maneuvering_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cfg_t    cfg;
  result_t step_res;

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    out_ready;
  logic    fire;

  // Result register frees when empty or when its transfer completes this cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  // The held command is evaluated (and state updated) only when it can move on.
  assign fire       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  ddmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ddmc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_item_q.kind          <= kind_i;
      s1_item_q.speed_percent <= speed_percent_i;
      s1_item_q.timed         <= timed_i;
      s1_item_q.duration_ms   <= duration_ms_i;
      s1_item_q.angle         <= angle_i;
      s1_item_q.notify        <= notify_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_percent_o   = out_res_q.left_percent;
  assign right_percent_o  = out_res_q.right_percent;
  assign motor_update_o   = out_res_q.motor_update;
  assign maneuver_done_o  = out_res_q.maneuver_done;
  assign done_kind_o      = out_res_q.done_kind;
  assign done_parameter_o = out_res_q.done_parameter;
  assign moving_o         = out_res_q.moving;
  assign maneuvering_o    = out_res_q.maneuvering;

`ifndef SYNTHESIS
  // A completion report always comes with a full stop.
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.maneuver_done) |->
      (out_res_q.motor_update && out_res_q.left_percent == 8'sd0 &&
       out_res_q.right_percent == 8'sd0 && !out_res_q.moving && !out_res_q.maneuvering))
    else $error("completion report without full stop");

  // Wheel fields stay zero when no motor command is issued.
  a_idle_wheels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.motor_update) |->
      (out_res_q.left_percent == 8'sd0 && out_res_q.right_percent == 8'sd0))
    else $error("wheel drive without motor update");

  // Input side stalls only while a command is held behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stall without a blocked result");

  // A command evaluated while the result stage is free shows up next cycle.
  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("evaluated command lost");
`endif

endmodule
